// ----- sv/pdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared widths and the record carried along the divider chain.
// ----------------------------------------------------------------------------
package pdp_pkg;

    localparam int SW = 52;
    localparam int QW = 13;
    localparam int DW = SW + QW;
    localparam int NPAIR = 6;

    localparam logic [2:0] IDX_EXTENT = 3'd6;
    localparam logic [2:0] IDX_REJECT = 3'd7;

    typedef struct packed {
        logic          vld;
        logic [DW-1:0] rem_c;
        logic [DW-1:0] rem_r;
        logic [SW-1:0] div;
        logic [QW-1:0] q_c;
        logic [QW-1:0] q_r;
        logic          bad_c;
        logic          bad_r;
        logic          ok_depth;
        logic [31:0]   depth;
        logic          scan_end;
    } cell_t;

endpackage
`default_nettype wire

// ----- sv/pdp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdp_front
// Matrix product, row sums, magnitudes and range checks ahead of the divider.
// ----------------------------------------------------------------------------
module pdp_front (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             adv,
    input  wire                             s_valid,
    input  wire signed [31:0]               s_point_x,
    input  wire signed [31:0]               s_point_y,
    input  wire signed [31:0]               s_point_z,
    input  wire                             s_last_point,
    input  wire [pdp_pkg::NPAIR-1:0][63:0]  cfg_pair,
    input  wire                             cfg_reject,
    output pdp_pkg::cell_t                  cell_o
);

    localparam int SW = pdp_pkg::SW;
    localparam int QW = pdp_pkg::QW;
    localparam int DW = pdp_pkg::DW;

    logic               vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic               end1_reg, end2_reg, end3_reg, end4_reg;
    logic signed [31:0] pt_reg [3];
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] prod_next [3][3];
    logic signed [31:0] off_reg [3];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic signed [63:0] acc;
    logic [SW-1:0]      mag_reg [3];
    logic [SW-1:0]      mag_next [3];
    logic [2:0]         neg_reg;
    logic [1:0]         zero_reg;
    logic               okd_reg;
    logic               okd_next;
    logic [31:0]        dep_reg;
    logic [31:0]        dep_next;
    pdp_pkg::cell_t     cell_reg;
    pdp_pkg::cell_t     cell_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = $signed(cfg_pair[2*r + c/2][(c%2)*32 +: 32]) * pt_reg[c];
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int r = 0; r < 3; r++) begin
            acc = 64'(off_reg[r]) + (prod_reg[r][0] >>> 16) + (prod_reg[r][1] >>> 16)
                + (prod_reg[r][2] >>> 16);
            sum_next[r] = acc[SW-1:0];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mag_next[r] = sum_reg[r][SW-1] ? SW'(-sum_reg[r]) : sum_reg[r];
        end
        okd_next = (sum_reg[2] != '0) && !(cfg_reject && sum_reg[2][SW-1]);
        if (sum_reg[2][SW-1:31] == '0 || sum_reg[2][SW-1:31] == '1) begin
            dep_next = sum_reg[2][31:0];
        end else if (sum_reg[2][SW-1]) begin
            dep_next = 32'h8000_0000;
        end else begin
            dep_next = 32'h7FFF_FFFF;
        end
    end

    always_comb begin
        logic [DW-1:0] top;
        top = {mag_reg[2], QW'(0)};
        cell_next.vld = vld4_reg;
        cell_next.rem_c = DW'(mag_reg[0]);
        cell_next.rem_r = DW'(mag_reg[1]);
        cell_next.div = mag_reg[2];
        cell_next.q_c = '0;
        cell_next.q_r = '0;
        cell_next.bad_c = (DW'(mag_reg[0]) >= top)
            || ((neg_reg[0] != neg_reg[2]) && !zero_reg[0] && (mag_reg[0] >= mag_reg[2]));
        cell_next.bad_r = (DW'(mag_reg[1]) >= top)
            || ((neg_reg[1] != neg_reg[2]) && !zero_reg[1] && (mag_reg[1] >= mag_reg[2]));
        cell_next.ok_depth = okd_reg;
        cell_next.depth = dep_reg;
        cell_next.scan_end = end4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            cell_reg <= '0;
        end else if (adv) begin
            vld1_reg <= s_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            cell_reg <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_reg[0] <= s_point_x;
            pt_reg[1] <= s_point_y;
            pt_reg[2] <= s_point_z;
            end1_reg <= s_last_point;
            prod_reg <= prod_next;
            for (int r = 0; r < 3; r++) begin
                off_reg[r] <= $signed(cfg_pair[2*r+1][63:32]);
            end
            end2_reg <= end1_reg;
            sum_reg <= sum_next;
            end3_reg <= end2_reg;
            mag_reg <= mag_next;
            neg_reg <= {sum_reg[2][SW-1], sum_reg[1][SW-1], sum_reg[0][SW-1]};
            zero_reg <= {sum_reg[1] == '0, sum_reg[0] == '0};
            okd_reg <= okd_next;
            dep_reg <= dep_next;
            end4_reg <= end3_reg;
        end
    end

    assign cell_o = cell_reg;

endmodule
`default_nettype wire

// ----- sv/pdp_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdp_div_cell
// One restoring-division step: decide one quotient bit of column and row.
// ----------------------------------------------------------------------------
module pdp_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            adv,
    input  pdp_pkg::cell_t cell_i,
    output pdp_pkg::cell_t cell_o
);

    localparam int DW = pdp_pkg::DW;

    logic [DW-1:0]  dsh;
    pdp_pkg::cell_t cell_reg;
    pdp_pkg::cell_t cell_next;

    assign dsh = DW'(cell_i.div) << SHIFT;

    always_comb begin
        cell_next = cell_i;
        if (cell_i.rem_c >= dsh) begin
            cell_next.rem_c = cell_i.rem_c - dsh;
            cell_next.q_c[SHIFT] = 1'b1;
        end
        if (cell_i.rem_r >= dsh) begin
            cell_next.rem_r = cell_i.rem_r - dsh;
            cell_next.q_r[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (adv) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_o = cell_reg;

endmodule
`default_nettype wire

// ----- sv/point_to_pixel_projector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one point per cycle; the whole pipe advances while the output
// register is empty or being taken.
// Reset: synchronous active-low aresetn clears all stage valids and the
// configuration registers to zero.
// ----------------------------------------------------------------------------
// point_to_pixel_projector
// Projects 3D points through a 3x4 matrix and divides into pixel coordinates.
// ----------------------------------------------------------------------------
module point_to_pixel_projector (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire  [2:0]        cfg_index,
    input  wire  [63:0]       cfg_data,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire signed [31:0] s_point_x,
    input  wire signed [31:0] s_point_y,
    input  wire signed [31:0] s_point_z,
    input  wire               s_last_point,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [12:0]       m_pixel_col,
    output logic [12:0]       m_pixel_row,
    output logic signed [31:0] m_depth,
    output logic              m_in_frame,
    output logic              m_scan_end
);

    localparam int QW = pdp_pkg::QW;

    logic [pdp_pkg::NPAIR-1:0][63:0] pair_reg;
    logic [27:0]    extent_reg;
    logic           reject_reg;
    logic           adv;
    logic           ok;
    pdp_pkg::cell_t chain [QW+1];
    logic           vld_reg;
    logic [12:0]    col_reg, row_reg;
    logic [31:0]    dep_reg;
    logic           inf_reg, end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
            extent_reg <= '0;
            reject_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == pdp_pkg::IDX_EXTENT) begin
                extent_reg <= cfg_data[27:0];
            end else if (cfg_index == pdp_pkg::IDX_REJECT) begin
                reject_reg <= cfg_data[0];
            end else begin
                pair_reg[cfg_index] <= cfg_data;
            end
        end
    end

    assign adv = !vld_reg || m_ready;
    assign s_ready = adv;

    pdp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .s_valid     (s_valid),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_point_z   (s_point_z),
        .s_last_point(s_last_point),
        .cfg_pair    (pair_reg),
        .cfg_reject  (reject_reg),
        .cell_o      (chain[0])
    );

    for (genvar i = 0; i < QW; i++) begin : g_cell
        pdp_div_cell #(.SHIFT(QW-1-i)) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .adv    (adv),
            .cell_i (chain[i]),
            .cell_o (chain[i+1])
        );
    end

    assign ok = chain[QW].ok_depth && !chain[QW].bad_c && !chain[QW].bad_r
        && ({1'b0, chain[QW].q_c} < extent_reg[13:0])
        && ({1'b0, chain[QW].q_r} < extent_reg[27:14]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= chain[QW].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            col_reg <= ok ? chain[QW].q_c : '0;
            row_reg <= ok ? chain[QW].q_r : '0;
            dep_reg <= chain[QW].depth;
            inf_reg <= ok;
            end_reg <= chain[QW].scan_end;
        end
    end

    assign m_valid = vld_reg;
    assign m_pixel_col = col_reg;
    assign m_pixel_row = row_reg;
    assign m_depth = dep_reg;
    assign m_in_frame = inf_reg;
    assign m_scan_end = end_reg;

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stall");

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_frame) |-> (m_pixel_col == '0 && m_pixel_row == '0))
        else $error("out-of-frame result carries a pixel");

    a_last_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[QW].vld && adv) |=> m_valid)
        else $error("result lost at output stage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[QW].vld && !adv) |=> chain[QW].vld)
        else $error("chain dropped an item while stalled");

endmodule
`default_nettype wire
